FILE: hw/rtl/rml_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rml_pkg - shared types and constants of the recent item list
// Depth of the list, field widths, operation codes and the cell command set.
// ----------------------------------------------------------------------------
package rml_pkg;

    // Number of list entries (1 to 64)
    localparam int LIST_DEPTH = 32;
    localparam int POS_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int LEN_W      = $clog2(LIST_DEPTH + 1);

    // Field widths
    localparam int IDX_W  = 16;
    localparam int CSUM_W = 32;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 72;

    // Operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Register indexes of the configuration port
    localparam logic CFG_RESERVED = 1'b0;
    localparam logic CFG_WAYPOINT = 1'b1;

    // One list entry
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  item;
        logic [CSUM_W-1:0] csum;
    } entry_t;

    // Per-cell command for an update cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT,
        CELL_CLEAR
    } cell_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/recent_item_mru_list_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// recent_item_mru_list_core - move-to-front list of recent item indices
// Row of list cells with a shared checksum unit and one output register.
// ----------------------------------------------------------------------------
// Each operation has a transfer cycle, in which the checksum operands are
// registered, and an update cycle in which every cell compares its index, the
// first match is picked and an insert or remove shifts the row by one place
// at once. No new item is taken before the last is updated; the next transfer
// is taken while a result still waits in the output register, and the update
// stalls only when that register is still full. Configuration writes take
// effect at once and should be made while no operation is in flight.
// ----------------------------------------------------------------------------
module recent_item_mru_list_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port
    input  wire logic                          cfg_wen,
    input  wire logic                          cfg_index,
    input  wire logic [15:0]                   cfg_wdata,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // op[1:0], item_index[17:2], read_position[23:18], name_first_char[31:24],
    // altitude_whole[47:32], latitude_whole[55:48], longitude_whole[64:56]
    input  wire logic [rml_pkg::S_DATA_W-1:0]  s_tdata,
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // was_present[0], found_position[7:1], entry_count[14:8],
    // dropped_last[15], entry_item[32:16], entry_checksum[64:33]
    output logic [rml_pkg::M_DATA_W-1:0]       m_tdata
);
    import rml_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t            state_reg;
    logic [7:0]        reserved_reg;
    logic [15:0]       waypoint_reg;
    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [5:0]        rpos_reg;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic              out_valid_reg;
    logic              out_present_reg, out_present_next;
    logic [6:0]        out_fpos_reg, out_fpos_next;
    logic [6:0]        out_count_reg;
    logic              out_drop_reg, out_drop_next;
    logic [16:0]       out_item_reg, out_item_next;
    logic [CSUM_W-1:0] out_csum_reg, out_csum_next;

    logic              accept;
    logic              apply;
    logic [CSUM_W-1:0] new_csum;

    entry_t            cell_entry [LIST_DEPTH];
    entry_t            cell_left  [LIST_DEPTH];
    entry_t            cell_right [LIST_DEPTH];
    cell_cmd_t         cell_cmd   [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] match;
    entry_t            new_entry;

    logic              found;
    logic [POS_W-1:0]  fpos;
    logic [POS_W-1:0]  ins_pos;
    logic              full;
    logic              rd_hit;
    entry_t            rd_entry;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign apply    = (state_reg == ST_APPLY) && (!out_valid_reg || m_tready);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reserved_reg <= '0;
            waypoint_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_RESERVED: reserved_reg <= cfg_wdata[7:0];
                CFG_WAYPOINT: waypoint_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Operation fields held for the update cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= op_t'(s_tdata[1:0]);
            idx_reg  <= s_tdata[17:2];
            rpos_reg <= s_tdata[23:18];
        end
    end

    rml_checksum u_checksum (
        .aclk            (aclk),
        .load            (accept),
        .item_index      (s_tdata[17:2]),
        .name_first_char (s_tdata[31:24]),
        .altitude_whole  (s_tdata[47:32]),
        .latitude_whole  (s_tdata[55:48]),
        .longitude_whole (s_tdata[64:56]),
        .reserved_count  (reserved_reg),
        .waypoint_count  (waypoint_reg),
        .csum            (new_csum)
    );

    assign new_entry = '{valid: 1'b1, item: idx_reg, csum: new_csum};

    // Row of cells with neighbour links
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign cell_left[g] = '0;
        end else begin : g_inner_l
            assign cell_left[g] = cell_entry[g-1];
        end
        if (g == LIST_DEPTH - 1) begin : g_last
            assign cell_right[g] = '0;
        end else begin : g_inner_r
            assign cell_right[g] = cell_entry[g+1];
        end

        rml_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .cmd         (cell_cmd[g]),
            .search_idx  (idx_reg),
            .new_entry   (new_entry),
            .left_entry  (cell_left[g]),
            .right_entry (cell_right[g]),
            .entry       (cell_entry[g]),
            .match       (match[g])
        );
    end

    // First matching position
    always_comb begin
        found = 1'b0;
        fpos  = '0;
        for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                found = 1'b1;
                fpos  = POS_W'(i);
            end
        end
    end

    // Insert shift limit: found place, free slot, or last cell when full
    assign full    = (len_reg == LEN_W'(LIST_DEPTH));
    assign ins_pos = found ? fpos : (full ? POS_W'(LIST_DEPTH - 1) : POS_W'(len_reg));

    // Per-cell commands
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            cell_cmd[i] = CELL_HOLD;
            if (apply) begin
                case (op_reg)
                    OP_INSERT: begin
                        if (i == 0) begin
                            cell_cmd[i] = CELL_LOAD;
                        end else if (POS_W'(i) <= ins_pos) begin
                            cell_cmd[i] = CELL_TAKE_LEFT;
                        end
                    end
                    OP_REMOVE: begin
                        if (found && (POS_W'(i) >= fpos)) begin
                            cell_cmd[i] = CELL_TAKE_RIGHT;
                        end
                    end
                    OP_CLEAR: cell_cmd[i] = CELL_CLEAR;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Read selection
    assign rd_hit   = ({1'b0, rpos_reg} < 7'(len_reg));
    assign rd_entry = cell_entry[rpos_reg[POS_W-1:0]];

    // Result fields and new length
    always_comb begin
        len_next         = len_reg;
        out_present_next = 1'b0;
        out_fpos_next    = '0;
        out_drop_next    = 1'b0;
        out_item_next    = '1;
        out_csum_next    = '0;
        case (op_reg)
            OP_INSERT: begin
                out_present_next = found;
                out_fpos_next    = found ? 7'(fpos) : 7'(len_reg);
                out_drop_next    = !found && full;
                if (!found && !full) begin
                    len_next = LEN_W'(len_reg + 1'b1);
                end
                out_item_next = {1'b0, idx_reg};
                out_csum_next = new_csum;
            end
            OP_REMOVE: begin
                out_present_next = found;
                out_fpos_next    = found ? 7'(fpos) : 7'(len_reg);
                if (found) begin
                    len_next = LEN_W'(len_reg - 1'b1);
                end
            end
            OP_CLEAR: begin
                len_next = '0;
            end
            OP_READ: begin
                if (rd_hit) begin
                    out_item_next = {1'b0, rd_entry.item};
                    out_csum_next = rd_entry.csum;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer, list length and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (apply) begin
                        state_reg <= ST_IDLE;
                        len_reg   <= len_next;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // Output register: filled by an update, emptied by a result transfer
            if (apply) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (apply) begin
            out_present_reg <= out_present_next;
            out_fpos_reg    <= out_fpos_next;
            out_count_reg   <= 7'(len_next);
            out_drop_reg    <= out_drop_next;
            out_item_reg    <= out_item_next;
            out_csum_reg    <= out_csum_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_csum_reg, out_item_reg, out_drop_reg,
                       out_count_reg, out_fpos_reg, out_present_reg};

endmodule
`default_nettype wire

FILE: hw/rtl/rml_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rml_cell - one entry of the list
// Holds an item index and its checksum, compares against the searched index
// and takes a new entry, its left or right neighbour, or clears itself.
// ----------------------------------------------------------------------------
module rml_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire rml_pkg::cell_cmd_t        cmd,
    input  wire logic [rml_pkg::IDX_W-1:0] search_idx,
    input  wire rml_pkg::entry_t           new_entry,
    input  wire rml_pkg::entry_t           left_entry,
    input  wire rml_pkg::entry_t           right_entry,
    output rml_pkg::entry_t                entry,
    output logic                           match
);
    import rml_pkg::*;

    logic              valid_reg, valid_next;
    logic [IDX_W-1:0]  item_reg, item_next;
    logic [CSUM_W-1:0] csum_reg, csum_next;

    // Next entry from this cell's command
    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        csum_next  = csum_reg;
        case (cmd)
            CELL_LOAD: begin
                valid_next = new_entry.valid;
                item_next  = new_entry.item;
                csum_next  = new_entry.csum;
            end
            CELL_TAKE_LEFT: begin
                valid_next = left_entry.valid;
                item_next  = left_entry.item;
                csum_next  = left_entry.csum;
            end
            CELL_TAKE_RIGHT: begin
                valid_next = right_entry.valid;
                item_next  = right_entry.item;
                csum_next  = right_entry.csum;
            end
            CELL_CLEAR: begin
                valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        csum_reg <= csum_next;
    end

    assign entry = '{valid: valid_reg, item: item_reg, csum: csum_reg};
    assign match = valid_reg && (item_reg == search_idx);

endmodule
`default_nettype wire

FILE: hw/rtl/rml_checksum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rml_checksum - two-step item checksum
// char + alt*100 + |lat|*|lon|*1000, zero outside the valid index window.
// First step registers the base sum and |lat|*|lon|, second scales by 1000.
// ----------------------------------------------------------------------------
module rml_checksum (
    input  wire logic                       aclk,
    input  wire logic                       load,
    input  wire logic [rml_pkg::IDX_W-1:0]  item_index,
    input  wire logic [7:0]                 name_first_char,
    input  wire logic signed [15:0]         altitude_whole,
    input  wire logic signed [7:0]          latitude_whole,
    input  wire logic signed [8:0]          longitude_whole,
    input  wire logic [7:0]                 reserved_count,
    input  wire logic [15:0]                waypoint_count,
    output logic [rml_pkg::CSUM_W-1:0]      csum
);
    import rml_pkg::*;

    logic [CSUM_W-1:0] base_reg, base_next;
    logic [16:0]       prod_reg, prod_next;
    logic              zero_reg, zero_next;
    logic [31:0]       alt_ext;
    logic [7:0]        lat_abs;
    logic [8:0]        lon_abs;

    // First step: base sum, product of magnitudes, index window
    always_comb begin
        alt_ext   = {{16{altitude_whole[15]}}, altitude_whole};
        lat_abs   = latitude_whole[7] ? 8'(~latitude_whole + 8'sd1) : latitude_whole;
        lon_abs   = longitude_whole[8] ? 9'(~longitude_whole + 9'sd1) : longitude_whole;
        base_next = 32'({24'd0, name_first_char} + alt_ext * 32'd100);
        prod_next = {9'd0, lat_abs} * {8'd0, lon_abs};
        zero_next = (item_index < {8'd0, reserved_count}) || (item_index >= waypoint_count);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            base_reg <= base_next;
            prod_reg <= prod_next;
            zero_reg <= zero_next;
        end
    end

    // Second step: scale and add
    assign csum = zero_reg ? '0 : 32'(base_reg + {15'd0, prod_reg} * 32'd1000);

endmodule
`default_nettype wire

FILE: tb/sv/mru_list_checker.sv
// ----------------------------------------------------------------------------
// mru_list_checker - result checker for the recent item list
// Watches the configuration port and both stream channels. It keeps its own
// copy of the list, works out the reply to each accepted input transfer and
// compares every result transfer with the oldest reply still awaited.
// ----------------------------------------------------------------------------
module mru_list_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wen,
    input  wire logic                         cfg_index,
    input  wire logic [15:0]                  cfg_wdata,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [rml_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [rml_pkg::M_DATA_W-1:0] m_tdata,
    output int                                fail_count,
    output int                                pending
);
    import rml_pkg::*;

    typedef struct {
        logic        present;
        logic [6:0]  fpos;
        logic [6:0]  count;
        logic        dropped;
        logic [16:0] item;
        logic [31:0] csum;
    } list_reply_t;

    // Model copy of the list and of the registers
    logic [16:0] slot_item [LIST_DEPTH];
    logic [31:0] slot_sum  [LIST_DEPTH];
    int          slot_count;
    logic [7:0]  reserved_lim;
    logic [15:0] waypoint_lim;

    list_reply_t replies_awaited [$];
    int          errors = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic empty_list();
        for (int k = 0; k < LIST_DEPTH; k++) begin
            slot_item[k] = '1;
            slot_sum[k]  = '0;
        end
        slot_count = 0;
    endtask

    // Checksum of an item; zero outside the reserved..waypoint window
    function automatic logic [31:0] waypoint_sum(input logic [15:0] idx,
                                                 input logic [S_DATA_W-1:0] d);
        logic [31:0] alt;
        logic [31:0] lat;
        logic [31:0] lon;
        if (idx < reserved_lim || idx >= waypoint_lim)
            return '0;
        alt = {{16{d[47]}}, d[47:32]};
        lat = {{24{d[55]}}, d[55:48]};
        lon = {{23{d[64]}}, d[64:56]};
        if (lat[31])
            lat = -lat;
        if (lon[31])
            lon = -lon;
        return {24'd0, d[31:24]} + alt * 32'd100 + lat * 32'd1000 * lon;
    endfunction

    // Position of an item, or the entry count when absent
    function automatic int find_slot(input logic [15:0] idx);
        for (int p = 0; p < slot_count && p < LIST_DEPTH; p++)
            if (slot_item[p] == {1'b0, idx})
                return p;
        return slot_count;
    endfunction

    // Apply one operation to the model list and build its reply
    task automatic run_list_op(input logic [S_DATA_W-1:0] d, output list_reply_t r);
        op_t         op;
        logic [15:0] idx;
        logic [5:0]  rpos;
        int          pos;
        op   = op_t'(d[1:0]);
        idx  = d[17:2];
        rpos = d[23:18];
        r.present = 1'b0;
        r.fpos    = '0;
        r.dropped = 1'b0;
        r.item    = '1;
        r.csum    = '0;
        case (op)
            OP_INSERT: begin
                pos    = find_slot(idx);
                r.fpos = 7'(pos);
                if (pos < slot_count) begin
                    r.present = 1'b1;
                end else if (slot_count < LIST_DEPTH) begin
                    slot_count++;
                end else begin
                    pos       = LIST_DEPTH - 1;
                    r.dropped = 1'b1;
                end
                for (int k = pos; k > 0; k--) begin
                    slot_item[k] = slot_item[k-1];
                    slot_sum[k]  = slot_sum[k-1];
                end
                slot_item[0] = {1'b0, idx};
                slot_sum[0]  = waypoint_sum(idx, d);
                r.item = slot_item[0];
                r.csum = slot_sum[0];
            end
            OP_REMOVE: begin
                pos    = find_slot(idx);
                r.fpos = 7'(pos);
                if (pos < slot_count) begin
                    r.present = 1'b1;
                    for (int k = pos; k + 1 < slot_count; k++) begin
                        slot_item[k] = slot_item[k+1];
                        slot_sum[k]  = slot_sum[k+1];
                    end
                    slot_count--;
                    slot_item[slot_count] = '1;
                    slot_sum[slot_count]  = '0;
                end
            end
            OP_CLEAR: begin
                empty_list();
            end
            default: begin
                if (rpos < slot_count && rpos < LIST_DEPTH) begin
                    r.item = slot_item[rpos];
                    r.csum = slot_sum[rpos];
                end
            end
        endcase
        r.count = 7'(slot_count);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Everything is sampled at the rising edge
    always @(posedge aclk) begin : watch
        list_reply_t got;
        list_reply_t want;
        if (!aresetn) begin
            empty_list();
            reserved_lim = '0;
            waypoint_lim = '0;
            replies_awaited.delete();
        end else begin
            // result side first: a result can never belong to this edge's input
            if (m_tvalid && m_tready) begin
                got.present = m_tdata[0];
                got.fpos    = m_tdata[7:1];
                got.count   = m_tdata[14:8];
                got.dropped = m_tdata[15];
                got.item    = m_tdata[32:16];
                got.csum    = m_tdata[64:33];
                if (replies_awaited.size() == 0) begin
                    errors++;
                    $display("%0t: result transfer %h with nothing awaited", $time, m_tdata);
                end else begin
                    want = replies_awaited.pop_front();
                    compare_field("was_present", 32'(want.present), 32'(got.present));
                    compare_field("found_position", 32'(want.fpos), 32'(got.fpos));
                    compare_field("entry_count", 32'(want.count), 32'(got.count));
                    compare_field("dropped_last", 32'(want.dropped), 32'(got.dropped));
                    compare_field("entry_item", 32'(want.item), 32'(got.item));
                    compare_field("entry_checksum", want.csum, got.csum);
                end
            end
            if (cfg_wen) begin
                if (cfg_index == CFG_RESERVED)
                    reserved_lim = cfg_wdata[7:0];
                else
                    waypoint_lim = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                run_list_op(s_tdata, want);
                replies_awaited.push_back(want);
            end
        end
        fail_count <= errors;
        pending    <= replies_awaited.size();
    end

endmodule

FILE: tb/sv/recent_item_mru_list_core_test.sv
// ----------------------------------------------------------------------------
// recent_item_mru_list_core_test - top of the recent item list testbench
// Drives a directed burst and then random operation mixes over several
// register settings, with random idling on both channels and one long result
// stall per chosen phase. The checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module recent_item_mru_list_core_test;
    import rml_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 240;
    localparam int PHASES      = 8;
    localparam int LONG_HOLD   = 300;

    logic                aclk;
    logic                aresetn;
    logic                cfg_wen;
    logic                cfg_index;
    logic [15:0]         cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    int          fail_count;
    int          pending;
    bit          idle_on;
    bit          hold_request;
    int unsigned pool_max;
    int          cycles;
    int          op_tally [4];
    int          settings_used;

    recent_item_mru_list_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mru_list_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int idle_gap();
        return idle_on ? int'($urandom_range(0, 8)) : 0;
    endfunction

    // op[1:0], item_index[17:2], read_position[23:18], name_first_char[31:24],
    // altitude_whole[47:32], latitude_whole[55:48], longitude_whole[64:56]
    function automatic logic [S_DATA_W-1:0] pack_item(input op_t op, input logic [15:0] idx,
            input logic [5:0] rpos, input logic [7:0] ch, input logic [15:0] alt,
            input logic [7:0] lat, input logic [8:0] lon);
        logic [S_DATA_W-1:0] d;
        d        = '0;
        d[1:0]   = op;
        d[17:2]  = idx;
        d[23:18] = rpos;
        d[31:24] = ch;
        d[47:32] = alt;
        d[55:48] = lat;
        d[64:56] = lon;
        return d;
    endfunction

    // Mostly inserts on a small index pool so the list fills and hits often
    function automatic logic [S_DATA_W-1:0] random_item();
        int unsigned pick;
        op_t         op;
        logic [15:0] idx;
        logic [7:0]  lat;
        logic [8:0]  lon;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            op = OP_INSERT;
        else if (pick < 72)
            op = OP_REMOVE;
        else if (pick < 73)
            op = OP_CLEAR;
        else
            op = OP_READ;
        idx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, pool_max));
        lat = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 180) - 90);
        lon = ($urandom_range(0, 7) == 0) ? 9'($urandom) : 9'($urandom_range(0, 360) - 180);
        return pack_item(op, idx, 6'($urandom), 8'($urandom), 16'($urandom), lat, lon);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic [S_DATA_W-1:0] d);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        op_tally[d[1:0]]++;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Stop offering and wait until every awaited result has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_regs(input logic [7:0] rsv, input logic [15:0] wpt);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_RESERVED;
        cfg_wdata <= {8'd0, rsv};
        @(negedge aclk);
        cfg_index <= CFG_WAYPOINT;
        cfg_wdata <= wpt;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        settings_used++;
    endtask

    // Result side: random hold-off after each transfer, long stall on request
    initial begin : receiver
        int hold;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                hold = idle_gap();
            if (hold_request) begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("recent_item_mru_list_core test failed");
        $finish;
    end

    initial begin : stimulus
        logic [7:0]  rsv_set [PHASES];
        logic [15:0] wpt_set [PHASES];
        int unsigned pool_set [PHASES];
        rsv_set  = '{8'd0, 8'd255, 8'd10, 8'd0, 8'd255, 8'($urandom), 8'($urandom), 8'd3};
        wpt_set  = '{16'd0, 16'hFFFF, 16'd50, 16'hFFFF, 16'd0, 16'($urandom),
                     16'($urandom_range(0, 120)), 16'd30};
        pool_set = '{40, 200, 60, 35, 1000, 45, 40, 120};
        aresetn      = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        pool_max     = 40;
        settings_used = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list cases, field extremes, moves, removes, clear
        write_regs(8'd2, 16'hFFFF);
        send_item(pack_item(OP_READ, 16'd0, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_REMOVE, 16'd5, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_INSERT, 16'd0, 6'd0, 8'd0, 16'h8000, -8'sd90, -9'sd180));
        send_item(pack_item(OP_INSERT, 16'hFFFF, 6'd0, 8'hFF, 16'h7FFF, 8'sd90, 9'sd180));
        send_item(pack_item(OP_INSERT, 16'd7, 6'd63, 8'hFF, 16'h7FFF, 8'sd90, 9'sd180));
        send_item(pack_item(OP_INSERT, 16'd8, 6'd0, 8'd0, 16'h8000, -8'sd90, -9'sd180));
        send_item(pack_item(OP_INSERT, 16'd9, 6'd0, 8'h41, 16'h1234, 8'h80, 9'h100));
        send_item(pack_item(OP_INSERT, 16'd0, 6'd0, 8'h5A, 16'd1, 8'sd1, 9'sd1));
        send_item(pack_item(OP_INSERT, 16'd7, 6'd0, 8'h01, 16'hFFFF, 8'h7F, 9'h0FF));
        send_item(pack_item(OP_READ, 16'd0, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_READ, 16'd0, 6'd3, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_READ, 16'hFFFF, 6'd63, 8'hFF, 16'hFFFF, 8'hFF, 9'h1FF));
        send_item(pack_item(OP_READ, 16'd0, 6'd31, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_REMOVE, 16'd8, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_REMOVE, 16'hFFFF, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_REMOVE, 16'd9, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_REMOVE, 16'd9, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_CLEAR, 16'd0, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        send_item(pack_item(OP_READ, 16'd0, 6'd0, 8'd0, 16'd0, 8'd0, 9'd0));
        drain();

        // Random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            write_regs(rsv_set[ph], wpt_set[ph]);
            pool_max = pool_set[ph];
            idle_on  = (ph % 3 != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // back-pressure: results pile up and the input stalls
                if ((ph == 2 || ph == 5) && n == 60)
                    hold_request = 1'b1;
                send_item(random_item());
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        $display("%0d inserts, %0d removes, %0d clears and %0d reads sent",
                 op_tally[OP_INSERT], op_tally[OP_REMOVE], op_tally[OP_CLEAR], op_tally[OP_READ]);
        $display("under %0d register settings, with random idling and long result stalls",
                 settings_used);
        if (fail_count == 0)
            $display("recent_item_mru_list_core test passed");
        else
            $display("recent_item_mru_list_core test failed");
        $finish;
    end

endmodule
